// ===== rtl/core/tecc_pkg.sv =====
// Shared types and constants for the tiny eight-op core.
`default_nettype none
package tecc_pkg;

  localparam int REG_COUNT = 8;
  localparam int RAW       = 3;   // register number width
  localparam int QDEPTH    = 4;   // front-to-back queue entries
  localparam int QAW       = 2;

  // instruction word field positions
  localparam int OP_POS  = 17;
  localparam int DST_POS = 14;
  localparam int SRC_POS = 11;
  localparam int TGT_POS = 8;

  typedef enum logic [1:0] {
    FUNC_EXEC  = 2'd0,
    FUNC_WREG  = 2'd1,
    FUNC_SETPC = 2'd2,
    FUNC_WBYTE = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_STORE = 3'd1,
    OP_ADD   = 3'd2,
    OP_ADDI  = 3'd3,
    OP_MUL   = 3'd4,
    OP_INV   = 3'd5,
    OP_BEQ   = 3'd6,
    OP_HALT  = 3'd7
  } op_t;

  // decoded item as it sits in the queue
  typedef struct packed {
    func_t            func;
    op_t              op;
    logic [RAW-1:0]   dst;   // register select for register writes too
    logic [RAW-1:0]   src;
    logic [RAW-1:0]   tgt;
    logic [7:0]       imm;
    logic [7:0]       wval;
    logic [7:0]       baddr;
  } item_t;

  typedef struct packed {
    logic [7:0]     next_pc;
    logic           is_halted;
    logic           reg_written;
    logic [RAW-1:0] reg_number;
    logic [7:0]     reg_result;
    logic           store_done;
    logic [7:0]     store_address;
    logic [7:0]     store_value;
    logic           branch_taken;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/core/tiny_eight_op_cpu_core_unit.sv =====
// Top level of the tiny eight-op core.
// The core takes one item per cycle while its queue has room, and returns one result per item, in order.
// An accepted item enters a four-entry queue; the back end reads operands and
// the data store in one stage and executes, retires and updates the register
// file, pc and halt flag in the next, then the result sits in an output
// register. The back end takes one item per cycle unless the output register
// is held by out_ready; the data store's single registered read port is used
// once per item. Register results and store writes are bypassed to the
// following item, so back-to-back dependent instructions run at full rate. The
// data store keeps one valid bit per byte, so it reads as zero after reset
// with no clearing pass.
`default_nettype none
module tiny_eight_op_cpu_core_unit #(
  parameter int DATA_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  func,
  input  wire logic [19:0] instr_word,
  input  wire logic [2:0]  reg_select,
  input  wire logic [7:0]  write_value,
  input  wire logic [7:0]  byte_address,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       next_pc,
  output logic             is_halted,
  output logic             reg_written,
  output logic [2:0]       reg_number,
  output logic [7:0]       reg_result,
  output logic             store_done,
  output logic [7:0]       store_address,
  output logic [7:0]       store_value,
  output logic             branch_taken
);
  import tecc_pkg::*;

  logic  q_valid;
  item_t q_item;
  logic  q_pop;
  res_t  res;

  tecc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .instr_word   (instr_word),
    .reg_select   (reg_select),
    .write_value  (write_value),
    .byte_address (byte_address),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  tecc_back #(
    .DATA_DEPTH(DATA_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign next_pc       = res.next_pc;
  assign is_halted     = res.is_halted;
  assign reg_written   = res.reg_written;
  assign reg_number    = res.reg_number;
  assign reg_result    = res.reg_result;
  assign store_done    = res.store_done;
  assign store_address = res.store_address;
  assign store_value   = res.store_value;
  assign branch_taken  = res.branch_taken;

endmodule
`default_nettype wire

// ===== rtl/core/tecc_front.sv =====
// Front end: accepts items, decodes instruction fields and queues them.
`default_nettype none
module tecc_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       func,
  input  wire logic [19:0]      instr_word,
  input  wire logic [2:0]       reg_select,
  input  wire logic [7:0]       write_value,
  input  wire logic [7:0]       byte_address,
  output logic                  q_valid,
  output tecc_pkg::item_t       q_item,
  input  wire logic             q_pop
);
  import tecc_pkg::*;

  item_t          fifo [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  item_t          dec;
  logic           push;
  logic           pop;

  always_comb begin
    dec.func  = func_t'(func);
    dec.op    = op_t'(instr_word[OP_POS +: 3]);
    dec.dst   = (func_t'(func) == FUNC_WREG) ? reg_select : instr_word[DST_POS +: RAW];
    dec.src   = instr_word[SRC_POS +: RAW];
    dec.tgt   = instr_word[TGT_POS +: RAW];
    dec.imm   = instr_word[7:0];
    dec.wval  = write_value;
    dec.baddr = byte_address;
  end

  assign in_ready = (count != (QAW+1)'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tecc_dmem.sv =====
// Data store: one write port, one registered read port, per-entry valid bits.
`default_nettype none
module tecc_dmem #(
  parameter int DATA_DEPTH = 256,
  localparam int AW = $clog2(DATA_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic [7:0]         rdata
);
  import tecc_pkg::*;

  logic [7:0]            mem [DATA_DEPTH];
  logic [DATA_DEPTH-1:0] vld;
  logic [7:0]            rd_q;
  logic                  rv_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      rv_q <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      if (re) begin
        rv_q <= vld[raddr];
      end
    end
  end

  // never-written entries read as zero
  assign rdata = rv_q ? rd_q : 8'd0;

endmodule
`default_nettype wire

// ===== rtl/core/tecc_back.sv =====
// Back end: operand read stage, execute stage and output register.
`default_nettype none
module tecc_back #(
  parameter int DATA_DEPTH = 256
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire tecc_pkg::item_t  q_item,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output tecc_pkg::res_t        res
);
  import tecc_pkg::*;

  localparam int AW = $clog2(DATA_DEPTH);

  typedef logic [255:0][AW-1:0] mod_tbl_t;

  // byte address folded into the store, built by counting
  function automatic mod_tbl_t build_mod_tbl();
    mod_tbl_t t;
    int       k;
    k = 0;
    for (int i = 0; i < 256; i++) begin
      t[i] = AW'(k);
      if (k == DATA_DEPTH - 1) begin
        k = 0;
      end else begin
        k = k + 1;
      end
    end
    return t;
  endfunction

  localparam mod_tbl_t MOD_TBL = build_mod_tbl();

  logic [7:0]     rf [REG_COUNT];
  logic [7:0]     pc;
  logic           halted;

  // execute stage registers
  logic           b_valid;
  item_t          b_item;
  logic [7:0]     b_a;
  logic [7:0]     b_b;
  logic [AW-1:0]  b_addr;
  logic           b_fwd_hit;
  logic [7:0]     b_fwd_data;

  // execute stage results
  logic           rw;
  logic [RAW-1:0] rnum;
  logic [7:0]     rres;
  logic           sd;
  logic [7:0]     sval;
  logic [7:0]     saddr;
  logic           bt;
  logic [7:0]     pc_next;
  logic           halted_next;
  logic           mem_we;
  logic [7:0]     mem_wdata;
  logic [7:0]     mem_rdata;
  logic [7:0]     ld_data;
  logic           b_fire;

  // operand stage
  logic           a_adv;
  logic [7:0]     op_a;
  logic [7:0]     op_b;
  logic [AW-1:0]  a_addr;

  res_t           o_res;

  assign b_fire  = b_valid && (!out_valid || out_ready);
  assign a_adv   = q_valid && (!b_valid || b_fire);
  assign q_pop   = a_adv;
  assign ld_data = b_fwd_hit ? b_fwd_data : mem_rdata;

  always_comb begin
    rw          = 1'b0;
    rnum        = '0;
    rres        = 8'd0;
    sd          = 1'b0;
    sval        = 8'd0;
    saddr       = 8'd0;
    bt          = 1'b0;
    pc_next     = pc;
    halted_next = halted;
    mem_we      = 1'b0;
    mem_wdata   = b_item.wval;
    case (b_item.func)
      FUNC_EXEC: begin
        if (!halted) begin
          pc_next = pc + 8'd1;
          case (b_item.op)
            OP_LOAD: begin
              rw   = 1'b1;
              rres = ld_data;
            end
            OP_STORE: begin
              sd        = 1'b1;
              saddr     = 8'(b_addr);
              sval      = b_a;
              mem_we    = 1'b1;
              mem_wdata = b_a;
            end
            OP_ADD: begin
              rw   = 1'b1;
              rres = b_a + b_b;
            end
            OP_ADDI: begin
              rw   = 1'b1;
              rres = b_a + b_item.imm;
            end
            OP_MUL: begin
              rw   = 1'b1;
              rres = {4'd0, b_a[3:0]} * {4'd0, b_a[7:4]};
            end
            OP_INV: begin
              rw   = 1'b1;
              rres = ~b_a;
            end
            OP_BEQ: begin
              if (b_a == b_b) begin
                bt      = 1'b1;
                pc_next = b_item.imm;
              end
            end
            OP_HALT: begin
              halted_next = 1'b1;
            end
            default: ;
          endcase
          if (rw) begin
            rnum = b_item.dst;
          end
        end
      end
      FUNC_WREG: begin
        rw   = 1'b1;
        rnum = b_item.dst;
        rres = b_item.wval;
      end
      FUNC_SETPC: begin
        pc_next = b_item.wval;
      end
      FUNC_WBYTE: begin
        mem_we = 1'b1;
      end
      default: ;
    endcase
  end

  // operand read with bypass from the item retiring this cycle
  always_comb begin
    op_a = rf[q_item.src];
    op_b = rf[q_item.tgt];
    if (b_fire && rw && (rnum == q_item.src)) begin
      op_a = rres;
    end
    if (b_fire && rw && (rnum == q_item.tgt)) begin
      op_b = rres;
    end
    a_addr = (q_item.func == FUNC_WBYTE) ? MOD_TBL[q_item.baddr] : MOD_TBL[op_b];
  end

  tecc_dmem #(
    .DATA_DEPTH(DATA_DEPTH)
  ) u_dmem (
    .clk   (clk),
    .rst   (rst),
    .we    (b_fire && mem_we),
    .waddr (b_addr),
    .wdata (mem_wdata),
    .re    (a_adv),
    .raddr (a_addr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_item     <= q_item;
      b_a        <= op_a;
      b_b        <= op_b;
      b_addr     <= a_addr;
      // the read misses a write landing on the same edge
      b_fwd_hit  <= b_fire && mem_we && (b_addr == a_addr);
      b_fwd_data <= mem_wdata;
    end
    if (b_fire) begin
      o_res.next_pc       <= pc_next;
      o_res.is_halted     <= halted_next;
      o_res.reg_written   <= rw;
      o_res.reg_number    <= rnum;
      o_res.reg_result    <= rres;
      o_res.store_done    <= sd;
      o_res.store_address <= saddr;
      o_res.store_value   <= sval;
      o_res.branch_taken  <= bt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        rf[i] <= 8'd0;
      end
      pc        <= 8'd0;
      halted    <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (b_fire) begin
        pc     <= pc_next;
        halted <= halted_next;
        if (rw) begin
          rf[rnum] <= rres;
        end
      end
      if (a_adv) begin
        b_valid <= 1'b1;
      end else if (b_fire) begin
        b_valid <= 1'b0;
      end
      if (b_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign res = o_res;

endmodule
`default_nettype wire

// ===== rtl/core/tecc_checker.sv =====
// Port-level checks for the tiny eight-op core, bound to the top level.
`default_nettype none
module tecc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  next_pc,
  input wire logic        is_halted,
  input wire logic        reg_written,
  input wire logic [2:0]  reg_number,
  input wire logic [7:0]  reg_result,
  input wire logic        store_done,
  input wire logic [7:0]  store_address,
  input wire logic [7:0]  store_value,
  input wire logic        branch_taken
);
  import tecc_pkg::*;

  logic seen_halt;

  // halt is sticky until reset
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_halt <= 1'b0;
    end else if (out_valid && out_ready && is_halted) begin
      seen_halt <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(next_pc) && $stable(reg_result))
    else $error("result changed while stalled");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen_halt |-> is_halted)
    else $error("halt flag dropped without reset");

  a_one_effect: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({reg_written, store_done, branch_taken}))
    else $error("result reports more than one effect");

  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reg_written && !store_done |->
      reg_number == 3'd0 && reg_result == 8'd0 && store_address == 8'd0 &&
      store_value == 8'd0)
    else $error("unused result fields not zero");

endmodule

bind tiny_eight_op_cpu_core_unit tecc_checker u_tecc_checker (.*);
`default_nettype wire
